@@ rtl/spg_pkg.sv @@
package spg_pkg;

    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam int POS_W     = 32;
    localparam int SPD_W     = 24;
    localparam int ACC_W     = 24;
    localparam int TGT_W     = 23;
    localparam int CNT_W     = 7;

    localparam int DT_W      = 16;
    localparam int DA_W      = 23;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MARGIN = 2'd3;

    localparam logic [DT_W-1:0] RST_TIME_STEP    = 16'd1311;
    localparam logic [DA_W-1:0] RST_ACCEL_STEP   = 23'd13107;
    localparam logic [DA_W-1:0] RST_ACCEL_LIMIT  = 23'd655360;
    localparam logic [DA_W-1:0] RST_SPEED_MARGIN = 23'd32768;

    localparam int P_W     = 50;
    localparam int V_W     = 47;
    localparam int A_W     = 31;
    localparam int FRAC_SH = P_W - POS_W;
    localparam int VSH     = 16;
    localparam int MAG_W   = A_W - 1;

    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;

    typedef struct packed {
        logic [DT_W-1:0] time_step;
        logic [DA_W-1:0] accel_step;
        logic [DA_W-1:0] accel_limit;
        logic [DA_W-1:0] speed_margin;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_DD,
        ST_DECIDE,
        ST_DIV,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_Q4,
        ST_Q5,
        ST_Q6,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_OUT
    } t_state;

endpackage

@@ rtl/spg_mul.sv @@
module spg_mul import spg_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/spg_div.sv @@
module spg_div import spg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [DA_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quot,
    output logic [DA_W-1:0]  o_rem
);

    localparam int IT_W = $clog2(MAG_W);
    localparam logic [IT_W-1:0] IT_LAST = IT_W'(MAG_W - 1);

    logic            r_busy;
    logic            r_done;
    logic [IT_W-1:0] r_it;
    logic [MAG_W-1:0] r_quo;
    logic [DA_W-1:0]  r_rem;
    logic [DA_W-1:0]  r_dvs;

    logic [DA_W:0] shifted;
    logic [DA_W:0] trial;
    logic          fits;

    assign shifted = {r_rem, r_quo[MAG_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_it   <= '0;
            end else if (r_busy) begin
                r_it <= r_it + 1'b1;
                if (r_it == IT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[MAG_W-2:0], fits};
            r_rem <= fits ? trial[DA_W-1:0] : shifted[DA_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ rtl/spg_core.sv @@
module spg_core import spg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_start,
    input  logic [POS_W-1:0]        i_start_position,
    input  logic signed [SPD_W-1:0] i_start_speed,
    input  logic signed [ACC_W-1:0] i_start_accel,
    input  logic [TGT_W-1:0]        i_cruise_speed,
    input  logic [POS_W-1:0]        i_position_limit,
    input  logic [CNT_W-1:0]        i_step_count,
    output logic                    o_busy,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [POS_W-1:0]        o_position,
    output logic                    o_last
);

    localparam int SV_W   = V_W + 2;
    localparam int SA_W   = A_W + 2;
    localparam int GAP_W  = V_W + 1;
    localparam int Q_W    = 62;
    localparam int QBIG   = V_W;
    localparam int QDT_W  = 64;
    localparam int ADT_W  = V_W + 1;
    localparam int PACC_W = 52;
    localparam int PS_W   = P_W + 4;
    localparam int ASH    = 17;

    localparam logic signed [SV_W-1:0] V_HI = $signed({3'b000, {(V_W-1){1'b1}}});
    localparam logic signed [SA_W-1:0] A_HI = $signed({3'b000, {(A_W-1){1'b1}}});

    t_state r_state, n_state;

    logic [P_W-1:0]           r_p;
    logic signed [V_W-1:0]    r_v;
    logic signed [A_W-1:0]    r_a;
    logic [TGT_W-1:0]         r_tgt;
    logic [POS_W-1:0]         r_lim;
    logic [STEP_W-1:0]        r_cnt;
    logic [STEP_W-1:0]        r_k;
    logic [2*DT_W-1:0]        r_dd;
    logic [Q_W-1:0]           r_q;
    logic [QDT_W-1:0]         r_acc;
    logic signed [ADT_W-1:0]  r_adt;
    logic signed [PACC_W-1:0] r_pacc;
    logic                     r_last;
    logic                     r_out_valid;
    logic [POS_W-1:0]         r_out_pos;
    logic                     r_out_last;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic                     div_done;
    logic [MAG_W-1:0]         div_quot;
    logic [DA_W-1:0]          div_rem;

    logic signed [SV_W-1:0] v_ext, tgt_ext, diff;
    logic [GAP_W-1:0]       gap;
    logic                   brake, in_band, predict, da_nz, dt_nz;
    logic [MAG_W-1:0]       mag;
    logic signed [A_W-1:0]  a_neg;
    logic signed [SA_W-1:0] a_ext, da_ext, amax_ext, a_up, a_dn, neg_cap;
    logic signed [SA_W-1:0] a_simple, a_pred;
    logic signed [A_W-1:0]  a_next;
    logic [QDT_W-1:0]       qdt;
    logic                   short_q, short_f;
    logic [Q_W-1:0]         q_sum;

    logic signed [PACC_W-1:0] vfrac, pdelta;
    logic signed [PS_W-1:0]   p_sum;
    logic [P_W-1:0]           p_new;
    logic signed [SV_W-1:0]   v_sum;
    logic signed [V_W-1:0]    v_new;
    logic [STEP_W-1:0]        k1;
    logic                     out_free;

    function automatic logic signed [A_W-1:0] sat_acc(input logic signed [SA_W-1:0] x);
        logic signed [SA_W-1:0] r;
        r = x;
        if (x > A_HI) begin
            r = A_HI;
        end else if (x < -A_HI) begin
            r = -A_HI;
        end
        return A_W'(r);
    endfunction

    spg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    spg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag),
        .i_divisor  (i_cfg.accel_step),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign da_nz   = i_cfg.accel_step != '0;
    assign dt_nz   = i_cfg.time_step != '0;
    assign v_ext   = SV_W'(r_v);
    assign tgt_ext = $signed({{(SV_W-TGT_W-VSH){1'b0}}, r_tgt, {VSH{1'b0}}});
    assign brake   = v_ext > tgt_ext;
    assign diff    = brake ? (v_ext - tgt_ext) : (tgt_ext - v_ext);
    assign gap     = diff[GAP_W-1:0];
    assign in_band = !brake && (gap < GAP_W'({i_cfg.speed_margin, {VSH{1'b0}}}));
    assign predict = !in_band && ((!brake && (r_a > 0)) || (brake && (r_a < 0)));
    assign a_neg   = -r_a;
    assign mag     = MAG_W'(brake ? a_neg : r_a);

    assign a_ext    = SA_W'(r_a);
    assign da_ext   = $signed(SA_W'(i_cfg.accel_step));
    assign amax_ext = $signed(SA_W'(i_cfg.accel_limit));
    assign a_up     = a_ext + da_ext;
    assign a_dn     = a_ext - da_ext;
    assign neg_cap  = da_ext - a_ext;

    assign qdt     = r_acc + {1'b0, prod[30:0], 32'd0};
    assign short_q = !dt_nz ? (gap != '0) : (!(|r_q[Q_W-1:QBIG]) && (qdt < QDT_W'(gap)));
    assign short_f = (r_state == ST_Q6) ? short_q : (gap != '0);

    always_comb begin
        if (in_band) begin
            a_simple = '0;
        end else if (brake) begin
            a_simple = a_dn;
        end else begin
            a_simple = a_up;
        end
        if (!brake) begin
            if (short_f) begin
                a_pred = (a_up < amax_ext) ? a_up : a_ext;
            end else begin
                a_pred = a_dn;
            end
        end else begin
            if (short_f) begin
                a_pred = (neg_cap < amax_ext) ? a_dn : a_ext;
            end else begin
                a_pred = a_up;
            end
        end
        a_next = sat_acc(predict ? a_pred : a_simple);
    end

    assign q_sum = Q_W'(r_acc) + Q_W'(prod[60:1]);

    assign vfrac  = $signed(PACC_W'(prod[31:VSH]));
    assign pdelta = r_pacc + vfrac;
    assign p_sum  = $signed(PS_W'(r_p)) + PS_W'(pdelta);

    always_comb begin
        if (p_sum[PS_W-1]) begin
            p_new = '0;
        end else if (|p_sum[PS_W-2:P_W]) begin
            p_new = '1;
        end else begin
            p_new = p_sum[P_W-1:0];
        end
    end

    assign v_sum = v_ext + SV_W'(r_adt);

    always_comb begin
        if (v_sum > V_HI) begin
            v_new = V_W'(V_HI);
        end else if (v_sum < -V_HI) begin
            v_new = V_W'(-V_HI);
        end else begin
            v_new = V_W'(v_sum);
        end
    end

    assign k1       = r_k + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && (i_step_count != '0) && (i_start_position < i_position_limit)) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT:   n_state = ST_DD;
            ST_DD:     n_state = ST_DECIDE;
            ST_DECIDE: n_state = (predict && da_nz) ? ST_DIV : ST_M1;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_Q1;
                end
            end
            ST_Q1: n_state = ST_Q2;
            ST_Q2: n_state = ST_Q3;
            ST_Q3: n_state = ST_Q4;
            ST_Q4: n_state = ST_Q5;
            ST_Q5: n_state = ST_Q6;
            ST_Q6: n_state = ST_M1;
            ST_M1: n_state = ST_M2;
            ST_M2: n_state = ST_M3;
            ST_M3: n_state = ST_M4;
            ST_M4: n_state = ST_M5;
            ST_M5: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = r_last ? ST_IDLE : ST_DECIDE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                mul_a = MUL_W'(i_cfg.time_step);
                mul_b = MUL_W'(i_cfg.time_step);
            end
            ST_DECIDE: begin
                div_start = predict && da_nz;
            end
            ST_Q1: begin
                mul_a = MUL_W'(div_quot);
                mul_b = MUL_W'(div_rem);
            end
            ST_Q2: begin
                mul_a = MUL_W'(mag - MAG_W'(div_rem));
                mul_b = MUL_W'((MAG_W + 1)'(div_quot) + 1'b1);
            end
            ST_Q4: begin
                mul_a = MUL_W'(r_q[31:0]);
                mul_b = MUL_W'(i_cfg.time_step);
            end
            ST_Q5: begin
                mul_a = MUL_W'(r_q[QBIG-1:32]);
                mul_b = MUL_W'(i_cfg.time_step);
            end
            ST_M1: begin
                mul_a = MUL_W'(r_a);
                mul_b = MUL_W'(i_cfg.time_step);
            end
            ST_M2: begin
                mul_a = MUL_W'(r_a);
                mul_b = MUL_W'(r_dd);
            end
            ST_M3: begin
                mul_a = MUL_W'($signed(r_v[V_W-1:VSH]));
                mul_b = MUL_W'(i_cfg.time_step);
            end
            ST_M4: begin
                mul_a = MUL_W'(r_v[VSH-1:0]);
                mul_b = MUL_W'(i_cfg.time_step);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_p   <= {i_start_position, {FRAC_SH{1'b0}}};
                r_v   <= {{(V_W-SPD_W-VSH){i_start_speed[SPD_W-1]}}, i_start_speed, {VSH{1'b0}}};
                r_a   <= A_W'(i_start_accel);
                r_tgt <= i_cruise_speed;
                r_lim <= i_position_limit;
                r_k   <= '0;
                if (int'(i_step_count) > MAX_STEPS) begin
                    r_cnt <= STEP_W'(MAX_STEPS);
                end else begin
                    r_cnt <= STEP_W'(i_step_count);
                end
            end
            ST_DD: r_dd <= prod[2*DT_W-1:0];
            ST_DECIDE: begin
                if (!(predict && da_nz)) begin
                    r_a <= a_next;
                end
            end
            ST_Q2: r_acc <= QDT_W'(prod[52:0]);
            ST_Q3: r_q   <= q_sum;
            ST_Q5: r_acc <= QDT_W'(prod[47:0]);
            ST_Q6: r_a   <= a_next;
            ST_M2: r_adt <= $signed(prod[ADT_W-1:0]);
            ST_M3: r_pacc <= PACC_W'(prod >>> ASH);
            ST_M4: r_pacc <= r_pacc + PACC_W'(prod);
            ST_M5: begin
                r_p    <= p_new;
                r_v    <= v_new;
                r_k    <= k1;
                r_last <= (k1 >= r_cnt) || (p_new[P_W-1:FRAC_SH] >= r_lim);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_out_pos  <= r_p[P_W-1:FRAC_SH];
            r_out_last <= r_last;
        end
    end

    assign o_busy      = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_last      = r_out_last;

endmodule

@@ rtl/speed_profile_position_generator_unit.sv @@
// channel   direction  handshake                  payload
// command   in         i_in_valid / o_in_stall    start_position .. step_count
// position  out        o_out_valid / i_out_stall  position, last
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A command yields one beat per step. A step takes longer when the relaxed-speed
// prediction runs the shared divider; every product comes from the single shared
// 33x33 multiplier. A command with beats first passes the setup states ST_INIT and
// ST_DD. The command channel stalls until the last beat is in the output register.
// Reset returns the configuration registers to their defaults; no other state is kept.
module speed_profile_position_generator_unit import spg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [POS_W-1:0]        i_start_position,
    input  logic signed [SPD_W-1:0] i_start_speed,
    input  logic signed [ACC_W-1:0] i_start_accel,
    input  logic [TGT_W-1:0]        i_cruise_speed,
    input  logic [POS_W-1:0]        i_position_limit,
    input  logic [CNT_W-1:0]        i_step_count,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [POS_W-1:0]        o_position,
    output logic                    o_last,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    t_cfg r_cfg;
    logic busy;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step    <= RST_TIME_STEP;
            r_cfg.accel_step   <= RST_ACCEL_STEP;
            r_cfg.accel_limit  <= RST_ACCEL_LIMIT;
            r_cfg.speed_margin <= RST_SPEED_MARGIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIME_STEP:    r_cfg.time_step    <= i_cfg_data[DT_W-1:0];
                CFG_ACCEL_STEP:   r_cfg.accel_step   <= i_cfg_data[DA_W-1:0];
                CFG_ACCEL_LIMIT:  r_cfg.accel_limit  <= i_cfg_data[DA_W-1:0];
                CFG_SPEED_MARGIN: r_cfg.speed_margin <= i_cfg_data[DA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept     = i_in_valid && !busy;
    assign o_in_stall = busy;

    spg_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_start          (accept),
        .i_start_position (i_start_position),
        .i_start_speed    (i_start_speed),
        .i_start_accel    (i_start_accel),
        .i_cruise_speed   (i_cruise_speed),
        .i_position_limit (i_position_limit),
        .i_step_count     (i_step_count),
        .o_busy           (busy),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_position       (o_position),
        .o_last           (o_last)
    );

endmodule

@@ verif/spg_position_checker.sv @@
module spg_position_checker import spg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [POS_W-1:0]        i_start_position,
    input  logic signed [SPD_W-1:0] i_start_speed,
    input  logic signed [ACC_W-1:0] i_start_accel,
    input  logic [TGT_W-1:0]        i_cruise_speed,
    input  logic [POS_W-1:0]        i_position_limit,
    input  logic [CNT_W-1:0]        i_step_count,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [POS_W-1:0]        i_position,
    input  logic                    i_last,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output int                      o_mismatches,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POS_MAX = (longint'(1) << 50) - 1;
    localparam longint VEL_MAX = (longint'(1) << 46) - 1;
    localparam longint ACC_MAX = (longint'(1) << 30) - 1;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last;
    } position_beat_t;

    t_cfg           settings;
    position_beat_t expected_positions[$];
    position_beat_t want;
    int             mismatch_count = 0;

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // true when the speed gained while |A| relaxes to zero stays short of the gap
    function automatic bit relax_falls_short(input longint mag, input longint gap);
        longint unsigned da, dt, n, r, q, g;
        da = settings.accel_step;
        dt = settings.time_step;
        q  = 0;
        if (da != 0) begin
            n = mag / da;
            r = mag - n * da;
            q = n * r + (n * da * (n + 1)) / 2;
        end
        if (dt == 0) begin
            return gap > 0;
        end
        g = (gap + dt - 1) / dt;
        return q < g;
    endfunction

    function automatic void plan_positions(
        input logic [POS_W-1:0]        start_pos,
        input logic signed [SPD_W-1:0] start_spd,
        input logic signed [ACC_W-1:0] start_acc,
        input logic [TGT_W-1:0]        tgt_spd,
        input logic [POS_W-1:0]        pos_lim,
        input logic [CNT_W-1:0]        steps
    );
        longint         p, v, a, tgt, lim, da, dt, amax, margin;
        int             cnt, k;
        bit             brake;
        position_beat_t beat;
        p      = longint'(start_pos) << 18;
        v      = longint'(start_spd) * 65536;
        a      = longint'(start_acc);
        tgt    = longint'(tgt_spd) * 65536;
        lim    = longint'(pos_lim) << 18;
        da     = longint'(settings.accel_step);
        dt     = longint'(settings.time_step);
        amax   = longint'(settings.accel_limit);
        margin = longint'(settings.speed_margin) * 65536;
        cnt    = (steps > MAX_STEPS) ? MAX_STEPS : int'(steps);
        k      = 0;
        while (k < cnt && p < lim) begin
            brake = v > tgt;
            if (!brake && tgt - v < margin) begin
                a = 0;
            end else if (!brake && a <= 0) begin
                a += da;
            end else if (brake && a >= 0) begin
                a -= da;
            end else if (!brake) begin
                if (relax_falls_short(a, tgt - v)) begin
                    if (a + da < amax) a += da;
                end else begin
                    a -= da;
                end
            end else begin
                if (relax_falls_short(-a, v - tgt)) begin
                    if (da - a < amax) a -= da;
                end else begin
                    a += da;
                end
            end
            a = clamp(a, -ACC_MAX, ACC_MAX);
            p += ((v * dt) >>> 16) + ((a * dt * dt) >>> 17);
            p = clamp(p, 0, POS_MAX);
            v = clamp(v + a * dt, -VEL_MAX, VEL_MAX);
            beat.position = p[49:18];
            beat.last     = (k + 1 >= cnt) || (p >= lim);
            expected_positions.insert(expected_positions.size(), beat);
            k++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings.time_step    = RST_TIME_STEP;
            settings.accel_step   = RST_ACCEL_STEP;
            settings.accel_limit  = RST_ACCEL_LIMIT;
            settings.speed_margin = RST_SPEED_MARGIN;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                plan_positions(i_start_position, i_start_speed, i_start_accel,
                               i_cruise_speed, i_position_limit, i_step_count);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_positions.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual position %0d last %0b",
                             $time, i_position, i_last);
                    mismatch_count++;
                end else begin
                    want = expected_positions.pop_front();
                    if (i_position !== want.position) begin
                        $display("%0t: position mismatch, expected %0d, actual %0d",
                                 $time, want.position, i_position);
                        mismatch_count++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch at position %0d, expected %0b, actual %0b",
                                 $time, want.position, want.last, i_last);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIME_STEP:    settings.time_step    = i_cfg_data[DT_W-1:0];
                    CFG_ACCEL_STEP:   settings.accel_step   = i_cfg_data[DA_W-1:0];
                    CFG_ACCEL_LIMIT:  settings.accel_limit  = i_cfg_data[DA_W-1:0];
                    CFG_SPEED_MARGIN: settings.speed_margin = i_cfg_data[DA_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_positions.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ verif/speed_profile_position_generator_unit_test.sv @@
module speed_profile_position_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import spg_pkg::*;

    localparam int CYCLE_LIMIT   = 10000000;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [POS_W-1:0] POS_TOP = 32'hFFFF_FFFF;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    in_valid       = 1'b0;
    logic                    in_stall;
    logic [POS_W-1:0]        start_position = '0;
    logic signed [SPD_W-1:0] start_speed    = '0;
    logic signed [ACC_W-1:0] start_accel    = '0;
    logic [TGT_W-1:0]        cruise_speed   = '0;
    logic [POS_W-1:0]        position_limit = '0;
    logic [CNT_W-1:0]        step_count     = '0;
    logic                    out_valid;
    logic                    out_stall      = 1'b0;
    logic [POS_W-1:0]        position;
    logic                    last;
    logic                    cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index      = CFG_TIME_STEP;
    logic [CFG_W-1:0]        cfg_data       = '0;

    int   pending;
    int   mismatches;
    int   cycle_count   = 0;
    int   stall_left    = 0;
    logic calm          = 1'b0;
    logic idle_allowed  = 1'b1;

    always #1 clk = ~clk;

    speed_profile_position_generator_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_start_position (start_position),
        .i_start_speed    (start_speed),
        .i_start_accel    (start_accel),
        .i_cruise_speed   (cruise_speed),
        .i_position_limit (position_limit),
        .i_step_count     (step_count),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_position       (position),
        .o_last           (last),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    spg_position_checker position_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_start_position (start_position),
        .i_start_speed    (start_speed),
        .i_start_accel    (start_accel),
        .i_cruise_speed   (cruise_speed),
        .i_position_limit (position_limit),
        .i_step_count     (step_count),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_position       (position),
        .i_last           (last),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver backpressure in bursts, with calm stretches
    always @(posedge clk) begin
        if ($urandom_range(0, 299) == 0) calm <= !calm;
        if (!idle_allowed || calm) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_command(
        input logic [POS_W-1:0]        pos,
        input logic signed [SPD_W-1:0] spd,
        input logic signed [ACC_W-1:0] acc,
        input logic [TGT_W-1:0]        tgt,
        input logic [POS_W-1:0]        lim,
        input logic [CNT_W-1:0]        cnt
    );
        in_valid       <= 1'b1;
        start_position <= pos;
        start_speed    <= spd;
        start_accel    <= acc;
        cruise_speed   <= tgt;
        position_limit <= lim;
        step_count     <= cnt;
        do @(posedge clk); while (in_stall);
        if (idle_allowed && !calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic random_command();
        logic [POS_W-1:0]        pos, lim;
        logic signed [SPD_W-1:0] spd, acc;
        logic [TGT_W-1:0]        tgt;
        logic [CNT_W-1:0]        cnt;
        longint                  span;
        int                      pick;
        pos = $urandom;
        if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 4095);
        tgt = TGT_W'($urandom);
        spd = SPD_W'($urandom);
        acc = ACC_W'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            spd = SPD_W'(int'(tgt) + int'($urandom_range(0, 262144)) - 131072);
        end
        if ($urandom_range(0, 1) == 0) begin
            acc = ACC_W'(int'($urandom_range(0, 262144)) - 131072);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            span = longint'($urandom_range(1, 1 << 20));
            lim  = (longint'(pos) + span > longint'(POS_TOP)) ? POS_TOP
                                                              : POS_W'(longint'(pos) + span);
        end else if (pick < 85) begin
            lim = $urandom;
        end else begin
            lim = (pos >= 1000) ? pos - $urandom_range(0, 1000) : '0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 80)      cnt = CNT_W'($urandom_range(0, 12));
        else if (pick < 95) cnt = CNT_W'($urandom_range(13, 64));
        else                cnt = CNT_W'($urandom_range(65, 127));
        send_command(pos, spd, acc, tgt, lim, cnt);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_settings(
        input logic [CFG_W-1:0] dt,
        input logic [CFG_W-1:0] da,
        input logic [CFG_W-1:0] amax,
        input logic [CFG_W-1:0] margin
    );
        wait_idle();
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_ACCEL_STEP, da);
        write_reg(CFG_ACCEL_LIMIT, amax);
        write_reg(CFG_SPEED_MARGIN, margin);
    endtask

    task automatic random_settings();
        logic [CFG_W-1:0] dt, da, amax, margin;
        dt     = CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 4000)
                                             : $urandom_range(1, 65535));
        da     = CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 100000)
                                             : $urandom_range(1, 8388607));
        amax   = CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 1000000)
                                             : $urandom_range(1, 8388607));
        margin = CFG_W'($urandom_range(0, 8388607));
        write_settings(dt, da, amax, margin);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_command(1000, 0, 0, 65536, 2000000, 0);
        send_command(5000, 65536, 0, 65536, 5000, 8);
        send_command(6000, 65536, 0, 65536, 5000, 8);
        send_command(0, 0, 0, 655360, POS_TOP, 1);
        send_command(100000, 655360, 0, 655360, POS_TOP, 4);
        send_command(100000, 640000, 0, 655360, POS_TOP, 6);
        send_command(100000, 1310720, 0, 655360, POS_TOP, 6);
        send_command(100000, 0, 300000, 1310720, POS_TOP, 10);
        send_command(100000, 1310720, -300000, 655360, POS_TOP, 10);
        send_command(100000, 0, 650000, 8388607, POS_TOP, 12);
        send_command(100000, 8388607, -650000, 0, POS_TOP, 12);
        send_command(0, -8388608, 0, 0, POS_TOP, 5);
        send_command(32'hFFFF_0000, 8388607, 8388607, 8388607, POS_TOP, 20);
        send_command(32'hFFFF_FFFE, 8388607, 8388607, 8388607, POS_TOP, 64);
        send_command(0, 8388607, -8388608, 8388607, POS_TOP, 64);
        send_command(0, 131072, 0, 8388607, POS_TOP, 65);
        send_command(0, -8388608, 8388607, 0, POS_TOP, 127);
        send_command(0, 8388607, 0, 8388607, 200000, 64);
        send_command(12345, 1000, -8388608, 0, 20000, 30);
        send_command(1 << 20, -500000, 8388607, 8388607, 1 << 21, 40);
        repeat (40) random_command();

        write_settings(65535, 8388607, 8388607, 8388607);
        repeat (40) random_command();

        write_settings(1, 1, 1, 0);
        repeat (40) random_command();

        // degenerate step sizes: dt and DA at zero
        write_settings(0, 0, CFG_W'($urandom_range(1, 8388607)),
                       CFG_W'($urandom_range(0, 8388607)));
        repeat (30) random_command();

        repeat (3) begin
            random_settings();
            repeat (40) random_command();
        end

        write_settings(RST_TIME_STEP, RST_ACCEL_STEP, RST_ACCEL_LIMIT, RST_SPEED_MARGIN);
        idle_allowed <= 1'b0;
        repeat (60) random_command();

        wait_idle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/spg_pkg.sv
rtl/spg_mul.sv
rtl/spg_div.sv
rtl/spg_core.sv
rtl/speed_profile_position_generator_unit.sv
verif/spg_position_checker.sv
verif/speed_profile_position_generator_unit_test.sv
